>>> rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and constants of the variable partition allocator
// Status codes, register indexes, fit policies and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package vpa_pkg;

  // Address and size width of the managed memory.
  localparam int AW = 16;

  // Reset values of the configuration registers.
  localparam logic [AW-1:0] RESET_TOTAL   = 16'd1024;
  localparam logic [AW-1:0] RESET_REMNANT = 16'd10;

  // Divide by 100 as multiply by ceil(2^23/100) and shift right by 23.
  localparam int            LIMIT_DIVISOR = 100;
  localparam int            RECIP_SHIFT   = 23;
  localparam logic [16:0]   RECIP_100     = 17'((64'd1 << RECIP_SHIFT) / LIMIT_DIVISOR + 1);

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OK_COMPACT = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_NO_ID      = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  // Request codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TOTAL  = 2'd0;
  localparam logic [1:0] CFG_FIT    = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  // Fit policies; any other code behaves as first fit.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_FIT_SCAN,
    OP_DECIDE,
    OP_CP_LOAD,
    OP_CP_ACC,
    OP_CP_COPY,
    OP_CP_FORMAT,
    OP_GRANT,
    OP_ID_SCAN,
    OP_ID_LOAD,
    OP_REL_SCAN,
    OP_MERGE,
    OP_EMIT
  } dp_op_t;

  // Command word from controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   clr_i;
    logic   inc_i;
    logic   clr_j;
    logic   inc_j;
  } dp_cmd_t;

  // Status word from datapath to controller.
  typedef struct packed {
    logic i_last_free;
    logic i_last_held;
    logic j_last;
    logic held_cur_used;
    logic slot_ok;
    logic space_ok;
    logic fit_found;
    logic hit_found;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator: first/best/worst fit block allocator
// Allocates blocks by id with splitting, compaction and coalescing on free.
// ----------------------------------------------------------------------------
// Allocate scans the free table, decides and grants; compaction adds the
// pairwise position sum over the held table before the grant.
// Free scans the held table for the id, then the free table for neighbors.
// One request is in work at a time; the next is taken once the result word
// is in the output register. Reset restores registers to 1024/first fit/10,
// clears the id counter and makes the whole memory one free block.
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int HELD_ENTRIES = 16,
  parameter int FREE_ENTRIES = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  input  logic [AW-1:0] req_size,
  input  logic [AW-1:0] target_id,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    status,
  output logic [AW-1:0] block_id,
  output logic [AW-1:0] base_addr,
  output logic [AW-1:0] granted_size,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [AW-1:0] cfg_data
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  // Register writes are taken at once.
  assign cfg_ready = 1'b1;

  // Request sequencer.
  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  // Tables and arithmetic.
  vpa_dp #(
    .HELD_ENTRIES (HELD_ENTRIES),
    .FREE_ENTRIES (FREE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .dcmd         (dcmd),
    .stat         (stat),
    .cmd          (cmd),
    .req_size     (req_size),
    .target_id    (target_id),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_id     (block_id),
    .base_addr    (base_addr),
    .granted_size (granted_size)
  );

  // An accepted word holds off the next one while it is in work.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in work");

  // Failed requests report neither address nor size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NO_SPACE || status == ST_NO_ID || status == ST_FULL))
    |-> (base_addr == '0 && granted_size == '0))
    else $error("failed request reports a block");

  // After compaction the grant comes from the block at address zero.
  a_compact_base: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK_COMPACT) |-> (base_addr == '0))
    else $error("compacted grant not at address zero");

endmodule

>>> rtl/core/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl: request sequencer of the variable partition allocator
// Walks each request through its scans, compaction and table updates by
// issuing one datapath operation per cycle unless the result word stalls.
// ----------------------------------------------------------------------------
module vpa_ctrl
  import vpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cmd,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_A_SCAN   = 13'b0000000000010,
    S_A_DECIDE = 13'b0000000000100,
    S_C_OUTER  = 13'b0000000001000,
    S_C_INNER  = 13'b0000000010000,
    S_C_COPY   = 13'b0000000100000,
    S_C_FORMAT = 13'b0000001000000,
    S_A_GRANT  = 13'b0000010000000,
    S_F_SCAN   = 13'b0000100000000,
    S_F_LOAD   = 13'b0001000000000,
    S_F_REL    = 13'b0010000000000,
    S_F_MERGE  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and operation select.
  always_comb begin
    state_next = state;
    dcmd       = '0;
    dcmd.op    = OP_NONE;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op    = OP_LATCH;
          dcmd.clr_i = 1'b1;
          state_next = (cmd == CMD_FREE) ? S_F_SCAN : S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        dcmd.op = OP_FIT_SCAN;
        if (stat.i_last_free) begin
          state_next = S_A_DECIDE;
        end else begin
          dcmd.inc_i = 1'b1;
        end
      end
      S_A_DECIDE: begin
        dcmd.op = OP_DECIDE;
        if (!stat.slot_ok || !stat.space_ok) begin
          state_next = S_DONE;
        end else if (stat.fit_found) begin
          state_next = S_A_GRANT;
        end else begin
          dcmd.clr_i = 1'b1;
          state_next = S_C_OUTER;
        end
      end
      S_C_OUTER: begin
        dcmd.op = OP_CP_LOAD;
        if (stat.held_cur_used) begin
          dcmd.clr_j = 1'b1;
          state_next = S_C_INNER;
        end else if (stat.i_last_held) begin
          dcmd.clr_i = 1'b1;
          state_next = S_C_COPY;
        end else begin
          dcmd.inc_i = 1'b1;
        end
      end
      S_C_INNER: begin
        dcmd.op = OP_CP_ACC;
        if (stat.j_last) begin
          if (stat.i_last_held) begin
            dcmd.clr_i = 1'b1;
            state_next = S_C_COPY;
          end else begin
            dcmd.inc_i = 1'b1;
            state_next = S_C_OUTER;
          end
        end else begin
          dcmd.inc_j = 1'b1;
        end
      end
      S_C_COPY: begin
        dcmd.op = OP_CP_COPY;
        if (stat.i_last_held) begin
          state_next = S_C_FORMAT;
        end else begin
          dcmd.inc_i = 1'b1;
        end
      end
      S_C_FORMAT: begin
        dcmd.op    = OP_CP_FORMAT;
        state_next = S_A_GRANT;
      end
      S_A_GRANT: begin
        dcmd.op    = OP_GRANT;
        state_next = S_DONE;
      end
      S_F_SCAN: begin
        dcmd.op = OP_ID_SCAN;
        if (stat.i_last_held) begin
          state_next = S_F_LOAD;
        end else begin
          dcmd.inc_i = 1'b1;
        end
      end
      S_F_LOAD: begin
        dcmd.op = OP_ID_LOAD;
        if (stat.hit_found) begin
          dcmd.clr_i = 1'b1;
          state_next = S_F_REL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_REL: begin
        dcmd.op = OP_REL_SCAN;
        if (stat.i_last_free) begin
          state_next = S_F_MERGE;
        end else begin
          dcmd.inc_i = 1'b1;
        end
      end
      S_F_MERGE: begin
        dcmd.op    = OP_MERGE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          dcmd.op    = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp: tables and arithmetic of the variable partition allocator
// Holds the free and held block tables, the configuration registers, the
// scan accumulators and the output word register.
// ----------------------------------------------------------------------------
module vpa_dp
  import vpa_pkg::*;
#(
  parameter int HELD_ENTRIES = 16,
  parameter int FREE_ENTRIES = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       dcmd,
  output dp_stat_t      stat,
  input  logic          cmd,
  input  logic [AW-1:0] req_size,
  input  logic [AW-1:0] target_id,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [AW-1:0] cfg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    status,
  output logic [AW-1:0] block_id,
  output logic [AW-1:0] base_addr,
  output logic [AW-1:0] granted_size
);

  localparam int HW   = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
  localparam int FW   = $clog2(FREE_ENTRIES);
  localparam int NMAX = (FREE_ENTRIES > HELD_ENTRIES) ? FREE_ENTRIES : HELD_ENTRIES;
  localparam int CW   = $clog2(NMAX);
  localparam int TW   = AW + $clog2(FREE_ENTRIES + 1);

  // Block tables.
  logic [AW-1:0]           free_start [FREE_ENTRIES];
  logic [AW-1:0]           free_len   [FREE_ENTRIES];
  logic [FREE_ENTRIES-1:0] free_used;
  logic [AW-1:0]           held_id    [HELD_ENTRIES];
  logic [AW-1:0]           held_start [HELD_ENTRIES];
  logic [AW-1:0]           held_len   [HELD_ENTRIES];
  logic [HELD_ENTRIES-1:0] held_used;
  logic [AW-1:0]           pos        [HELD_ENTRIES];

  // Configuration and id counter.
  logic [AW-1:0] remnant_limit, next_id;
  logic [1:0]    fit_policy;

  // Request and scan registers.
  logic [CW-1:0] i;
  logic [HW-1:0] j;
  logic [AW-1:0] req_q, tid_q, id_q;
  logic [FW-1:0] best_idx;
  logic [AW-1:0] best_start, best_len;
  logic          fit_found, compacted;
  logic [TW-1:0] sum_total;
  logic [HW-1:0] slot_idx;
  logic [AW-1:0] cur_start, acc;
  logic          hit_found;
  logic [HW-1:0] hit_idx;
  logic [AW-1:0] rel_start, rel_len;
  logic          prev_found, next_found;
  logic [FW-1:0] prev_idx, next_idx;
  logic [AW-1:0] prev_len, next_len;
  status_t       res_status;
  logic [AW-1:0] res_id, res_start, res_size;

  // Combinational helpers.
  logic [FW-1:0]    fi;
  logic [HW-1:0]    hi, hra;
  logic [AW-1:0]    h_start_rd, h_len_rd;
  logic [HW-1:0]    slot_enc;
  logic             slot_ok;
  logic [FW-1:0]    empty_enc;
  logic             empty_ok;
  logic             cand, better, take;
  logic             space_ok;
  logic             acc_hit;
  logic [AW-1:0]    acc_next;
  logic [AW:0]      fend, rel_end;
  logic [AW-1:0]    rem, granted;
  logic             whole;
  logic [AW+16:0]   limit_prod;
  logic             out_free;

  assign fi = i[FW-1:0];
  assign hi = i[HW-1:0];

  // One shared read address into the start and length columns of the held table.
  always_comb begin
    if (dcmd.op == OP_CP_ACC) begin
      hra = j;
    end else if (dcmd.op == OP_ID_LOAD) begin
      hra = hit_idx;
    end else begin
      hra = hi;
    end
  end
  assign h_start_rd = held_start[hra];
  assign h_len_rd   = held_len[hra];

  // First free slot of the held table and of the free table.
  always_comb begin
    slot_enc  = '0;
    empty_enc = '0;
    for (int k = HELD_ENTRIES - 1; k >= 0; k--) begin
      if (!held_used[k]) slot_enc = HW'(k);
    end
    for (int k = FREE_ENTRIES - 1; k >= 0; k--) begin
      if (!free_used[k]) empty_enc = FW'(k);
    end
  end
  assign slot_ok  = ~&held_used;
  assign empty_ok = ~&free_used;

  // Fit comparison of the scanned free entry against the best so far.
  assign cand = free_used[fi] && (free_len[fi] >= req_q);
  always_comb begin
    case (fit_policy)
      FIT_BEST: better = (free_len[fi] < best_len) ||
                         (free_len[fi] == best_len && free_start[fi] < best_start);
      FIT_WORST: better = (free_len[fi] > best_len) ||
                          (free_len[fi] == best_len && free_start[fi] < best_start);
      default: better = free_start[fi] < best_start;
    endcase
  end
  assign take     = cand && (!fit_found || better);
  assign space_ok = (req_q != '0) && (sum_total >= TW'(req_q));

  // Compaction: add lengths of held blocks that sit below the current one.
  assign acc_hit  = held_used[j] &&
                    ((h_start_rd < cur_start) || (h_start_rd == cur_start && j < hi));
  assign acc_next = acc + (acc_hit ? h_len_rd : '0);

  // Neighbor match for release.
  assign fend    = {1'b0, free_start[fi]} + {1'b0, free_len[fi]};
  assign rel_end = {1'b0, rel_start} + {1'b0, rel_len};

  // Grant split.
  assign rem     = best_len - req_q;
  assign whole   = rem <= remnant_limit;
  assign granted = whole ? best_len : req_q;

  // Remnant limit from a new total size.
  assign limit_prod = cfg_data * RECIP_100;

  assign out_free = !out_valid || !out_stall;

  // Status back to the controller.
  always_comb begin
    stat.i_last_free   = (i == CW'(FREE_ENTRIES - 1));
    stat.i_last_held   = (i == CW'(HELD_ENTRIES - 1));
    stat.j_last        = (j == HW'(HELD_ENTRIES - 1));
    stat.held_cur_used = held_used[hi];
    stat.slot_ok       = slot_ok;
    stat.space_ok      = space_ok;
    stat.fit_found     = fit_found;
    stat.hit_found     = hit_found;
    stat.out_free      = out_free;
  end

  // Control registers: configuration, flags, counters, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      remnant_limit <= RESET_REMNANT;
      fit_policy    <= FIT_FIRST;
      next_id       <= '0;
      free_used     <= FREE_ENTRIES'(1);
      held_used     <= '0;
      free_start[0] <= '0;
      free_len[0]   <= RESET_TOTAL;
      out_valid     <= 1'b0;
      i             <= '0;
      j             <= '0;
    end else begin
      // Counters.
      if (dcmd.clr_i) begin
        i <= '0;
      end else if (dcmd.inc_i) begin
        i <= i + 1'b1;
      end
      if (dcmd.clr_j) begin
        j <= '0;
      end else if (dcmd.inc_j) begin
        j <= j + 1'b1;
      end

      // Output word is loaded, or taken.
      if (dcmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Configuration writes; a nonzero total size reformats the memory.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOTAL: begin
            if (cfg_data != '0) begin
              remnant_limit <= AW'(limit_prod[AW+16:RECIP_SHIFT]);
              free_used     <= FREE_ENTRIES'(1);
              held_used     <= '0;
              free_start[0] <= '0;
              free_len[0]   <= cfg_data;
            end
          end
          CFG_FIT:   fit_policy    <= cfg_data[1:0];
          CFG_LIMIT: remnant_limit <= cfg_data;
          default: ;
        endcase
      end

      case (dcmd.op)
        OP_LATCH: begin
          req_q      <= req_size;
          tid_q      <= target_id;
          fit_found  <= 1'b0;
          sum_total  <= '0;
          hit_found  <= 1'b0;
          prev_found <= 1'b0;
          next_found <= 1'b0;
          compacted  <= 1'b0;
          if (cmd == CMD_ALLOC) begin
            next_id <= next_id + 1'b1;
            id_q    <= next_id + 1'b1;
          end else begin
            id_q    <= target_id;
          end
        end
        OP_FIT_SCAN: begin
          if (free_used[fi]) begin
            sum_total <= sum_total + TW'(free_len[fi]);
          end
          if (take) begin
            fit_found  <= 1'b1;
            best_idx   <= fi;
            best_start <= free_start[fi];
            best_len   <= free_len[fi];
          end
        end
        OP_DECIDE: begin
          slot_idx  <= slot_enc;
          res_id    <= id_q;
          res_start <= '0;
          res_size  <= '0;
          if (!slot_ok) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_NO_SPACE;
          end
        end
        OP_CP_LOAD: begin
          cur_start <= h_start_rd;
          acc       <= sum_total[AW-1:0];
        end
        OP_CP_ACC: begin
          acc <= acc_next;
          if (j == HW'(HELD_ENTRIES - 1)) begin
            pos[hi] <= acc_next;
          end
        end
        OP_CP_COPY: begin
          if (held_used[hi]) begin
            held_start[hi] <= pos[hi];
          end
        end
        OP_CP_FORMAT: begin
          free_used     <= FREE_ENTRIES'(1);
          free_start[0] <= '0;
          free_len[0]   <= sum_total[AW-1:0];
          best_idx      <= '0;
          best_start    <= '0;
          best_len      <= sum_total[AW-1:0];
          compacted     <= 1'b1;
        end
        OP_GRANT: begin
          if (whole) begin
            free_used[best_idx] <= 1'b0;
          end else begin
            free_start[best_idx] <= best_start + req_q;
            free_len[best_idx]   <= rem;
          end
          held_used[slot_idx]  <= 1'b1;
          held_id[slot_idx]    <= id_q;
          held_start[slot_idx] <= best_start;
          held_len[slot_idx]   <= granted;
          res_status <= compacted ? ST_OK_COMPACT : ST_OK;
          res_id     <= id_q;
          res_start  <= best_start;
          res_size   <= granted;
        end
        OP_ID_SCAN: begin
          if (!hit_found && held_used[hi] && held_id[hi] == tid_q) begin
            hit_found <= 1'b1;
            hit_idx   <= hi;
          end
        end
        OP_ID_LOAD: begin
          res_id <= tid_q;
          if (hit_found) begin
            rel_start          <= h_start_rd;
            rel_len            <= h_len_rd;
            held_used[hit_idx] <= 1'b0;
            res_status         <= ST_OK;
            res_start          <= h_start_rd;
            res_size           <= h_len_rd;
          end else begin
            res_status <= ST_NO_ID;
            res_start  <= '0;
            res_size   <= '0;
          end
        end
        OP_REL_SCAN: begin
          if (free_used[fi]) begin
            if (!prev_found && fend == {1'b0, rel_start}) begin
              prev_found <= 1'b1;
              prev_idx   <= fi;
              prev_len   <= free_len[fi];
            end else if (!next_found && {1'b0, free_start[fi]} == rel_end) begin
              next_found <= 1'b1;
              next_idx   <= fi;
              next_len   <= free_len[fi];
            end
          end
        end
        OP_MERGE: begin
          if (prev_found && next_found) begin
            free_len[prev_idx]  <= prev_len + rel_len + next_len;
            free_used[next_idx] <= 1'b0;
          end else if (prev_found) begin
            free_len[prev_idx] <= prev_len + rel_len;
          end else if (next_found) begin
            free_start[next_idx] <= rel_start;
            free_len[next_idx]   <= next_len + rel_len;
          end else if (empty_ok) begin
            free_used[empty_enc]  <= 1'b1;
            free_start[empty_enc] <= rel_start;
            free_len[empty_enc]   <= rel_len;
          end
        end
        OP_EMIT: begin
          status       <= res_status;
          block_id     <= res_id;
          base_addr    <= res_start;
          granted_size <= res_size;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the variable partition allocator
// Directed and random allocate/free words are sent through the request port
// while an in-bench model of the free and held tables predicts every result
// word. Configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import vpa_pkg::*;

  localparam int HELD_N = 16;
  localparam int FREE_N = 17;
  localparam int CYCLE_LIMIT = 2000000;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic          cmd;
  logic [AW-1:0] req_size;
  logic [AW-1:0] target_id;
  logic          out_valid;
  logic          out_stall;
  logic [2:0]    status;
  logic [AW-1:0] block_id;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] granted_size;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [AW-1:0] cfg_data;

  variable_partition_allocator dut (.*);

  // One expected result word.
  typedef struct {
    logic [2:0]    st;
    logic [AW-1:0] id;
    logic [AW-1:0] addr;
    logic [AW-1:0] len;
  } result_t;

  result_t expected_results[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  longint  cycle_count = 0;

  // Model of the allocator tables and registers.
  logic [AW-1:0] m_total, m_limit, m_next_id;
  logic [1:0]    m_fit;
  logic [AW-1:0] m_fstart[FREE_N];
  logic [AW-1:0] m_flen[FREE_N];
  bit            m_fused[FREE_N];
  logic [AW-1:0] m_hid[HELD_N];
  logic [AW-1:0] m_hstart[HELD_N];
  logic [AW-1:0] m_hlen[HELD_N];
  bit            m_hused[HELD_N];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter with run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void format_tables();
    for (int i = 0; i < FREE_N; i++) begin
      m_fused[i] = 0;
      m_fstart[i] = '0;
      m_flen[i] = '0;
    end
    for (int i = 0; i < HELD_N; i++) m_hused[i] = 0;
    m_fused[0] = 1;
    m_flen[0] = m_total;
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [AW-1:0] val);
    if (idx == CFG_TOTAL) begin
      if (val != 0) begin
        m_total = val;
        m_limit = AW'(val / LIMIT_DIVISOR);
        format_tables();
      end
    end else if (idx == CFG_FIT) begin
      m_fit = val[1:0];
    end else if (idx == CFG_LIMIT) begin
      m_limit = val;
    end
  endfunction

  function automatic int choose_block(logic [AW-1:0] req);
    int  pick;
    bit  take;
    pick = -1;
    for (int i = 0; i < FREE_N; i++) begin
      if (!m_fused[i] || m_flen[i] < req) continue;
      if (pick < 0) take = 1;
      else if (m_fit == FIT_BEST)
        take = m_flen[i] < m_flen[pick] ||
               (m_flen[i] == m_flen[pick] && m_fstart[i] < m_fstart[pick]);
      else if (m_fit == FIT_WORST)
        take = m_flen[i] > m_flen[pick] ||
               (m_flen[i] == m_flen[pick] && m_fstart[i] < m_fstart[pick]);
      else take = m_fstart[i] < m_fstart[pick];
      if (take) pick = i;
    end
    return pick;
  endfunction

  // Move every held block up in address order above the free total.
  function automatic void compact_memory(logic [AW-1:0] free_total);
    logic [AW-1:0] pos[HELD_N];
    logic [AW-1:0] p;
    for (int i = 0; i < HELD_N; i++) begin
      if (!m_hused[i]) continue;
      p = free_total;
      for (int j = 0; j < HELD_N; j++)
        if (m_hused[j] && (m_hstart[j] < m_hstart[i] ||
            (m_hstart[j] == m_hstart[i] && j < i)))
          p = p + m_hlen[j];
      pos[i] = p;
    end
    for (int i = 0; i < HELD_N; i++) if (m_hused[i]) m_hstart[i] = pos[i];
    for (int i = 0; i < FREE_N; i++) m_fused[i] = 0;
    m_fused[0] = 1;
    m_fstart[0] = '0;
    m_flen[0] = free_total;
  endfunction

  // Return a block to the free table, merging with its neighbors.
  function automatic void return_block(logic [AW-1:0] s, logic [AW-1:0] len);
    int  lo, hi;
    longint fin;
    lo = -1;
    hi = -1;
    fin = longint'(s) + len;
    for (int i = 0; i < FREE_N; i++) begin
      if (!m_fused[i]) continue;
      if (lo < 0 && longint'(m_fstart[i]) + m_flen[i] == s) lo = i;
      else if (hi < 0 && longint'(m_fstart[i]) == fin) hi = i;
    end
    if (lo >= 0 && hi >= 0) begin
      m_flen[lo] = m_flen[lo] + len + m_flen[hi];
      m_fused[hi] = 0;
    end else if (lo >= 0) begin
      m_flen[lo] = m_flen[lo] + len;
    end else if (hi >= 0) begin
      m_fstart[hi] = s;
      m_flen[hi] = m_flen[hi] + len;
    end else begin
      for (int i = 0; i < FREE_N; i++)
        if (!m_fused[i]) begin
          m_fused[i] = 1;
          m_fstart[i] = s;
          m_flen[i] = len;
          break;
        end
    end
  endfunction

  // Predict the result word of one request and update the model.
  function automatic result_t predict_result(logic c, logic [AW-1:0] req,
                                             logic [AW-1:0] tid);
    result_t r;
    int      slot, f, hit;
    longint  free_total;
    logic [AW-1:0] s, rem;
    r.addr = '0;
    r.len = '0;
    if (c == CMD_ALLOC) begin
      m_next_id = m_next_id + 1'b1;
      r.id = m_next_id;
      slot = -1;
      free_total = 0;
      for (int i = 0; i < HELD_N; i++) if (!m_hused[i]) begin slot = i; break; end
      for (int i = 0; i < FREE_N; i++) if (m_fused[i]) free_total += m_flen[i];
      if (slot < 0) r.st = ST_FULL;
      else if (req == 0 || free_total < req) r.st = ST_NO_SPACE;
      else begin
        f = choose_block(req);
        r.st = ST_OK;
        if (f < 0) begin
          compact_memory(AW'(free_total));
          f = 0;
          r.st = ST_OK_COMPACT;
        end
        s = m_fstart[f];
        rem = m_flen[f] - req;
        if (rem <= m_limit) begin
          r.len = m_flen[f];
          m_fused[f] = 0;
        end else begin
          r.len = req;
          m_fstart[f] = s + req;
          m_flen[f] = rem;
        end
        r.addr = s;
        m_hused[slot] = 1;
        m_hid[slot] = r.id;
        m_hstart[slot] = s;
        m_hlen[slot] = r.len;
      end
    end else begin
      r.id = tid;
      hit = -1;
      for (int i = 0; i < HELD_N; i++)
        if (m_hused[i] && m_hid[i] == tid) begin hit = i; break; end
      if (hit < 0) r.st = ST_NO_ID;
      else begin
        r.st = ST_OK;
        r.addr = m_hstart[hit];
        r.len = m_hlen[hit];
        m_hused[hit] = 0;
        return_block(r.addr, r.len);
      end
    end
    return r;
  endfunction

  // Receiver stall and result checking.
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            error_count++;
          end
          if (block_id !== e.id) begin
            $error("block_id expected %0d actual %0d", e.id, block_id);
            error_count++;
          end
          if (base_addr !== e.addr) begin
            $error("base_addr expected %0d actual %0d", e.addr, base_addr);
            error_count++;
          end
          if (granted_size !== e.len) begin
            $error("granted_size expected %0d actual %0d", e.len, granted_size);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request word; the prediction is made as it is accepted.
  // Valid stays high after the accepting edge until the caller sends the
  // next word, goes idle or waits for the block to drain.
  task automatic send_request(logic c, logic [AW-1:0] req, logic [AW-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    req_size <= req;
    target_id <= tid;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_result(c, req, tid));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [AW-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Pick a held id most of the time, otherwise any id.
  function automatic logic [AW-1:0] pick_id();
    int n;
    n = $urandom_range(HELD_N - 1);
    if ($urandom_range(9) < 8)
      for (int k = 0; k < HELD_N; k++)
        if (m_hused[(n + k) % HELD_N]) return m_hid[(n + k) % HELD_N];
    return AW'($urandom);
  endfunction

  // Directed: extremes, every status, compaction, coalescing.
  task automatic test_directed();
    send_request(CMD_ALLOC, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(CMD_FREE, 16'd0, 16'hFFFF);
    for (int i = 0; i < 17; i++) send_request(CMD_ALLOC, 16'd60, 16'd0);
    send_request(CMD_FREE, 16'd0, 16'd3);
    send_request(CMD_FREE, 16'd0, 16'd5);
    send_request(CMD_FREE, 16'd0, 16'd4);
    send_request(CMD_FREE, 16'd0, 16'd8);
    send_request(CMD_ALLOC, 16'd200, 16'd0);
  endtask

  // Random requests under the current configuration.
  task automatic test_random(int n, int maxsz);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55)
        send_request(CMD_ALLOC, ($urandom_range(49) == 0) ? AW'($urandom) :
                     AW'($urandom_range(maxsz)), AW'($urandom));
      else
        send_request(CMD_FREE, AW'($urandom), pick_id());
    end
  endtask

  task automatic test_policies();
    logic [1:0] fits[4] = '{FIT_FIRST, FIT_BEST, FIT_WORST, 2'd3};
    foreach (fits[k]) begin
      write_config(CFG_FIT, fits[k]);
      write_config(CFG_TOTAL, 16'd600);
      write_config(CFG_LIMIT, AW'($urandom_range(20)));
      test_random(150, 120);
    end
  endtask

  task automatic test_extremes();
    write_config(CFG_TOTAL, 16'hFFFF);
    write_config(CFG_LIMIT, 16'hFFFF);
    test_random(60, 65535);
    write_config(CFG_LIMIT, 16'd0);
    test_random(150, 12000);
    write_config(CFG_TOTAL, 16'd0);
    test_random(40, 8000);
    write_config(CFG_TOTAL, 16'd1);
    test_random(60, 2);
    write_config(CFG_TOTAL, AW'($urandom_range(300, 5000)));
    test_random(200, 400);
  endtask

  initial begin
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    req_size = '0;
    target_id = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOTAL;
    cfg_data = '0;
    m_total = RESET_TOTAL;
    m_limit = RESET_REMNANT;
    m_fit = FIT_FIRST;
    m_next_id = '0;
    format_tables();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150, 100);
    send_idle_pct = 55;
    test_policies();
    send_idle_pct = 0;
    stall_pct = 55;
    test_extremes();
    send_idle_pct = 15;
    stall_pct = 15;
    write_config(CFG_TOTAL, 16'd1024);
    test_random(250, 150);

    wait_idle();
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
